[src/gcs_pkg.sv]
// Package for the Gronsfeld stream cipher: alphabet constants, register index codes
// and the byte <-> alphabet index maps.
// No dependencies; used by gronsfeld_cipher_stream_top.
package gcs_pkg;

    localparam int unsigned KEY_DIGITS = 16;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned KEY_W      = KEY_DIGITS * DIGIT_W;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned LEN_W      = 5;

    localparam logic [7:0] ALPHA_SIZE  = 8'd161;
    localparam logic [7:0] HIGH_FIRST  = 8'd192;
    localparam logic [7:0] PRINT_FIRST = 8'd32;
    localparam logic [7:0] PRINT_LAST  = 8'd126;
    localparam logic [7:0] IDX_EXTRA_A = 8'd64;
    localparam logic [7:0] IDX_EXTRA_B = 8'd65;
    localparam logic [7:0] IDX_PRINT   = 8'd66;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] CHAR_TAB    = 8'd9;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_DIGITS);

    localparam logic [7:0] EXTRA_A_RST = 8'd168;
    localparam logic [7:0] EXTRA_B_RST = 8'd184;

    typedef enum logic [2:0] {
        CFG_KEY_DIGITS   = 3'd0,
        CFG_KEY_LENGTH   = 3'd1,
        CFG_DECRYPT_MODE = 3'd2,
        CFG_EXTRA_A      = 3'd3,
        CFG_EXTRA_B      = 3'd4
    } cfg_index_t;

    // Alphabet index of a byte; ALPHA_SIZE when the byte is outside the alphabet.
    // The lowest index wins when an extra letter repeats another symbol.
    function automatic logic [7:0] sym_index(input logic [7:0] b,
                                             input logic [7:0] extra_a,
                                             input logic [7:0] extra_b);
        logic [7:0] idx;
        if (b >= HIGH_FIRST) begin
            idx = b - HIGH_FIRST;
        end else if (b == extra_a) begin
            idx = IDX_EXTRA_A;
        end else if (b == extra_b) begin
            idx = IDX_EXTRA_B;
        end else if (b >= PRINT_FIRST && b <= PRINT_LAST) begin
            idx = b - PRINT_FIRST + IDX_PRINT;
        end else begin
            idx = ALPHA_SIZE;
        end
        return idx;
    endfunction

    function automatic logic [7:0] sym_byte(input logic [7:0] idx,
                                            input logic [7:0] extra_a,
                                            input logic [7:0] extra_b);
        logic [7:0] b;
        if (idx < IDX_EXTRA_A) begin
            b = idx + HIGH_FIRST;
        end else if (idx == IDX_EXTRA_A) begin
            b = extra_a;
        end else if (idx == IDX_EXTRA_B) begin
            b = extra_b;
        end else begin
            b = idx - IDX_PRINT + PRINT_FIRST;
        end
        return b;
    endfunction

endpackage

[src/gronsfeld_cipher_stream_top.sv]
// Top level of the Gronsfeld stream cipher: one byte in, one result out per cycle while the receiver is ready.
// Depends on gcs_pkg for constants, register index codes and the alphabet maps.
//
// This block shifts each message byte by the current key digit within a 161-symbol
// alphabet (bytes 192..255, two configurable extra letters, then bytes 32..126).
// Every input transaction produces exactly one output transaction, and while the
// receiver is ready a new byte can be taken in every cycle: the only storage on the
// data path is the output register, reloaded in the same cycle its data is taken,
// so the sustained rate is one byte per clock. Newline and tab pass unchanged and
// do not use a key digit. Any other byte outside the alphabet comes out with
// m_axis_tuser low and m_axis_tdata zero, and it still advances the key position.
// The key position wraps at the key length and restarts at digit 0 after a byte
// marked with s_axis_tlast. Key digits above 9 act as 9. Configuration writes go
// through the cfg channel, which is always ready; write it only while no byte is
// in flight.
module gronsfeld_cipher_stream_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_message

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] out_present
    output logic        m_axis_tlast,   // out_last

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers.
    logic [gcs_pkg::KEY_W-1:0] key_digits_reg;
    logic [gcs_pkg::LEN_W-1:0] key_length_reg;
    logic                      decrypt_mode_reg;
    logic [7:0]                extra_a_reg;
    logic [7:0]                extra_b_reg;

    // Key position and the output register.
    logic [gcs_pkg::POS_W-1:0] key_pos_reg;
    logic [gcs_pkg::POS_W-1:0] key_pos_next;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic [7:0]                out_byte_next;
    logic                      out_present_reg;
    logic                      out_present_next;
    logic                      out_last_reg;

    logic                      s_accept;
    logic                      cfg_write;
    logic                      is_passthru;
    logic [gcs_pkg::LEN_W-1:0] eff_len;
    logic [gcs_pkg::POS_W-1:0] pos_cur;
    logic [gcs_pkg::LEN_W-1:0] pos_inc;
    logic [3:0]                digit_raw;
    logic [3:0]                digit;
    logic [7:0]                idx_in;
    logic [7:0]                idx_sum;
    logic [7:0]                idx_out;

    // The output register is free when empty or when its transaction completes now.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_present_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_digits_reg   <= '0;
            key_length_reg   <= gcs_pkg::LEN_W'(1);
            decrypt_mode_reg <= 1'b0;
            extra_a_reg      <= gcs_pkg::EXTRA_A_RST;
            extra_b_reg      <= gcs_pkg::EXTRA_B_RST;
        end else if (cfg_write) begin
            unique case (gcs_pkg::cfg_index_t'(cfg_index))
                gcs_pkg::CFG_KEY_DIGITS:   key_digits_reg   <= cfg_data[gcs_pkg::KEY_W-1:0];
                gcs_pkg::CFG_KEY_LENGTH:   key_length_reg   <= cfg_data[gcs_pkg::LEN_W-1:0];
                gcs_pkg::CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                gcs_pkg::CFG_EXTRA_A:      extra_a_reg      <= cfg_data[7:0];
                gcs_pkg::CFG_EXTRA_B:      extra_b_reg      <= cfg_data[7:0];
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    always_comb begin
        is_passthru = (s_axis_tdata == gcs_pkg::CHAR_NL) ||
                      (s_axis_tdata == gcs_pkg::CHAR_TAB);

        // A zero length acts as one digit, anything above the key size as the full key.
        if (key_length_reg == '0) begin
            eff_len = gcs_pkg::LEN_W'(1);
        end else if (key_length_reg > gcs_pkg::LEN_MAX) begin
            eff_len = gcs_pkg::LEN_MAX;
        end else begin
            eff_len = key_length_reg;
        end

        // A position left beyond a shortened key restarts at digit 0.
        if (gcs_pkg::LEN_W'(key_pos_reg) >= eff_len) begin
            pos_cur = '0;
        end else begin
            pos_cur = key_pos_reg;
        end

        digit_raw = key_digits_reg[{pos_cur, 2'b00} +: gcs_pkg::DIGIT_W];
        digit     = (digit_raw > gcs_pkg::DIGIT_MAX) ? gcs_pkg::DIGIT_MAX : digit_raw;

        idx_in = gcs_pkg::sym_index(s_axis_tdata, extra_a_reg, extra_b_reg);

        if (decrypt_mode_reg) begin
            if (idx_in >= {4'd0, digit}) begin
                idx_out = idx_in - {4'd0, digit};
            end else begin
                idx_out = idx_in + (gcs_pkg::ALPHA_SIZE - {4'd0, digit});
            end
            idx_sum = '0;
        end else begin
            idx_sum = idx_in + {4'd0, digit};
            idx_out = (idx_sum >= gcs_pkg::ALPHA_SIZE) ? idx_sum - gcs_pkg::ALPHA_SIZE
                                                       : idx_sum;
        end

        if (is_passthru) begin
            out_byte_next    = s_axis_tdata;
            out_present_next = 1'b1;
        end else if (idx_in < gcs_pkg::ALPHA_SIZE) begin
            out_byte_next    = gcs_pkg::sym_byte(idx_out, extra_a_reg, extra_b_reg);
            out_present_next = 1'b1;
        end else begin
            out_byte_next    = '0;
            out_present_next = 1'b0;
        end

        // Newline and tab hold the position, other bytes step it; a last byte restarts it.
        pos_inc = gcs_pkg::LEN_W'(pos_cur) + gcs_pkg::LEN_W'(1);
        if (s_axis_tlast) begin
            key_pos_next = '0;
        end else if (is_passthru) begin
            key_pos_next = key_pos_reg;
        end else if (pos_inc >= eff_len) begin
            key_pos_next = '0;
        end else begin
            key_pos_next = pos_inc[gcs_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                key_pos_reg   <= key_pos_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_byte_reg    <= out_byte_next;
            out_present_reg <= out_present_next;
            out_last_reg    <= s_axis_tlast;
        end
    end

    // A dropped byte always comes out as zero.
    a_dropped_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("dropped byte carries nonzero data");

    // The last byte of a message restarts the key at digit 0.
    a_last_restarts_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=> (key_pos_reg == '0))
        else $error("key position not restarted after end of message");

    // Newline and tab pass unchanged, marked present.
    a_passthru_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_passthru) |=>
            (m_axis_tvalid && m_axis_tuser && m_axis_tdata == $past(s_axis_tdata)))
        else $error("newline or tab not passed through");

    // Newline and tab do not step the key position unless the message ends.
    a_passthru_holds_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_passthru && !s_axis_tlast) |=> $stable(key_pos_reg))
        else $error("key position stepped on newline or tab");

endmodule

[verif/tb_gronsfeld_cipher_stream_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gronsfeld_cipher_stream_top: directed and random byte traffic
// checked against an in-bench prediction of the cipher. Depends on gcs_pkg and the DUT.
module tb_gronsfeld_cipher_stream_top;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 10;
    // Idle gap kept after the last predicted result has come out.
    localparam int DRAIN_GAP   = 4;
    localparam int TIMEOUT_NS  = 400_000 * CLK_PERIOD;
    localparam int ITEMS_PER_PHASE = 230;

    typedef struct packed {
        logic [7:0] text;
        logic       present;
        logic       last;
    } cipher_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tuser;   // [0] out_present
    logic        m_axis_tlast;   // out_last
    logic        cfg_valid;
    logic        cfg_ready;
    gcs_pkg::cfg_index_t cfg_index;
    logic [63:0] cfg_data;

    // Predicted register contents and key position.
    logic [63:0] key_word;
    logic [4:0]  key_len_reg;
    logic        decrypt_reg;
    logic [7:0]  extra_a;
    logic [7:0]  extra_b;
    logic [3:0]  key_pos;

    cipher_out_t pending_cipher_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int bytes_sent;
    int bytes_dropped;
    int bytes_passed;
    int results_seen;
    int settings_loaded;

    gronsfeld_cipher_stream_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Position of a byte in the 161-symbol alphabet, or ALPHA_SIZE when it is not a letter.
    // High bytes are looked up first, so an extra letter that repeats one never wins.
    function automatic int alpha_index(input logic [7:0] b);
        if (b >= gcs_pkg::HIGH_FIRST) return int'(b) - int'(gcs_pkg::HIGH_FIRST);
        if (b == extra_a) return int'(gcs_pkg::IDX_EXTRA_A);
        if (b == extra_b) return int'(gcs_pkg::IDX_EXTRA_B);
        if (b >= gcs_pkg::PRINT_FIRST && b <= gcs_pkg::PRINT_LAST)
            return int'(gcs_pkg::IDX_PRINT) + int'(b) - int'(gcs_pkg::PRINT_FIRST);
        return int'(gcs_pkg::ALPHA_SIZE);
    endfunction

    function automatic logic [7:0] alpha_byte(input int idx);
        if (idx < int'(gcs_pkg::IDX_EXTRA_A)) return 8'(int'(gcs_pkg::HIGH_FIRST) + idx);
        if (idx == int'(gcs_pkg::IDX_EXTRA_A)) return extra_a;
        if (idx == int'(gcs_pkg::IDX_EXTRA_B)) return extra_b;
        return 8'(int'(gcs_pkg::PRINT_FIRST) + idx - int'(gcs_pkg::IDX_PRINT));
    endfunction

    // Ciphers one byte and moves the key position on, as the block does on acceptance.
    function automatic cipher_out_t cipher_step(input logic [7:0] b, input logic eom);
        cipher_out_t r;
        int len;
        int pos;
        int digit;
        int idx;
        int shifted;
        r.text    = 8'd0;
        r.present = 1'b0;
        r.last    = eom;
        if (b == gcs_pkg::CHAR_NL || b == gcs_pkg::CHAR_TAB) begin
            // Layout characters pass untouched and leave the key position alone.
            r.text    = b;
            r.present = 1'b1;
        end else begin
            len = int'(key_len_reg);
            if (len == 0) len = 1;
            if (len > int'(gcs_pkg::KEY_DIGITS)) len = int'(gcs_pkg::KEY_DIGITS);
            pos = int'(key_pos);
            if (pos >= len) pos = 0;   // stale position after a shorter key was loaded
            digit = int'(key_word[4*pos +: 4]);
            if (digit > int'(gcs_pkg::DIGIT_MAX)) digit = int'(gcs_pkg::DIGIT_MAX);
            idx = alpha_index(b);
            if (idx < int'(gcs_pkg::ALPHA_SIZE)) begin
                shifted = decrypt_reg ? idx - digit : idx + digit;
                if (shifted < 0) shifted += int'(gcs_pkg::ALPHA_SIZE);
                else if (shifted >= int'(gcs_pkg::ALPHA_SIZE))
                    shifted -= int'(gcs_pkg::ALPHA_SIZE);
                r.text    = alpha_byte(shifted);
                r.present = 1'b1;
            end
            // Dropped bytes still use up their key digit.
            pos++;
            if (pos >= len) pos = 0;
            key_pos = 4'(pos);
        end
        if (eom) key_pos = 4'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Offers one byte, with random idle cycles ahead of it, and records the prediction
    // at the edge where the transaction completes.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        cipher_out_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eom;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        want = cipher_step(b, eom);
        pending_cipher_q.push_back(want);
        bytes_sent++;
        if (!want.present) bytes_dropped++;
        else if (b == gcs_pkg::CHAR_NL || b == gcs_pkg::CHAR_TAB) bytes_passed++;
        @(negedge aclk);
    endtask

    // Stops the sender and waits until every predicted result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_cipher_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    // Writes all five registers back to back once the block is idle. The write valid
    // stays high across the five transactions and drops once at the end.
    task automatic load_settings(input logic [63:0] key, input logic [63:0] len,
                                 input logic [63:0] mode, input logic [63:0] letter_a,
                                 input logic [63:0] letter_b);
        gcs_pkg::cfg_index_t order [5];
        logic [63:0]         vals  [5];
        order = '{gcs_pkg::CFG_KEY_DIGITS, gcs_pkg::CFG_KEY_LENGTH, gcs_pkg::CFG_DECRYPT_MODE,
                  gcs_pkg::CFG_EXTRA_A, gcs_pkg::CFG_EXTRA_B};
        vals  = '{key, len, mode, letter_a, letter_b};
        drain_results();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            @(negedge aclk);
        end
        cfg_valid   <= 1'b0;
        key_word    = key;
        key_len_reg = len[4:0];
        decrypt_reg = mode[0];
        extra_a     = letter_a[7:0];
        extra_b     = letter_b[7:0];
        settings_loaded++;
    endtask

    // The receiver stalls at random, at the rate set for the current phase.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every result transaction is compared with the oldest prediction.
    always @(posedge aclk) begin : check_results
        cipher_out_t want;
        if (aresetn === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_cipher_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing predicted: data %02h present %b last %b",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = pending_cipher_q.pop_front();
                results_seen++;
                if (m_axis_tdata !== want.text || m_axis_tuser !== want.present ||
                    m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %02h present %b last %b, got %02h %b %b",
                                 $realtime, want.text, want.present, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the key is all zero digits of length one, so every letter
    // comes back as itself, including the two default extra letters.
    task automatic test_reset_values();
        send_byte(gcs_pkg::PRINT_FIRST, 1'b0);
        send_byte(gcs_pkg::EXTRA_A_RST, 1'b0);
        send_byte(gcs_pkg::EXTRA_B_RST, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd127, 1'b0);   // just above the printable range: dropped
        send_byte(8'd191, 1'b1);   // just below the high range: dropped
    endtask

    // Largest shift both ways across the alphabet seam, digits above nine clamped,
    // and the key position held on layout characters but reset at end of message.
    task automatic test_shift_wrap();
        load_settings(64'h0123_4567_89AB_CDEF, 64'd16, 64'd0, 64'd168, 64'd184);
        send_byte(gcs_pkg::PRINT_LAST, 1'b0);   // last letter wraps round to the high bytes
        send_byte(gcs_pkg::CHAR_NL, 1'b0);
        send_byte(8'd255, 1'b0);       // last high byte shifts past the extra letters into the printables
        send_byte(8'd0, 1'b0);         // dropped, but its digit is spent
        send_byte(8'd200, 1'b0);
        send_byte(gcs_pkg::CHAR_TAB, 1'b1);     // end of message on a tab restarts the key
        load_settings(64'h0123_4567_89AB_CDEF, 64'd16, 64'd1, 64'd168, 64'd184);
        send_byte(gcs_pkg::HIGH_FIRST, 1'b0);   // first letter wraps back to the printable end
        send_byte(8'd193, 1'b0);
        send_byte(8'd168, 1'b0);
        send_byte(gcs_pkg::PRINT_LAST, 1'b1);
    endtask

    // Extra letters that collide with layout characters, printable bytes and high bytes.
    task automatic test_extra_letters();
        load_settings(64'h1111_1111_1111_1111, 64'd3, 64'd0, 64'(gcs_pkg::CHAR_NL), 64'd65);
        send_byte(gcs_pkg::CHAR_NL, 1'b0);   // layout check comes before the alphabet lookup
        send_byte(8'd65, 1'b0);        // found as the extra letter, not as a printable
        send_byte(8'd64, 1'b0);
        send_byte(8'd255, 1'b1);       // shifts onto the extra letter that is a newline
        load_settings(64'h1111_1111_1111_1111, 64'd2, 64'd1, 64'd200, 64'(gcs_pkg::CHAR_TAB));
        send_byte(8'd200, 1'b0);       // the high byte keeps its own place
        send_byte(gcs_pkg::CHAR_TAB, 1'b0);
        send_byte(gcs_pkg::HIGH_FIRST, 1'b1);
    endtask

    // Key length zero, key length beyond the digit count, and a key position left
    // beyond a newly shortened key.
    task automatic test_key_length_limits();
        load_settings(64'hFEDC_BA98_7654_3213, 64'd0, 64'd0, 64'd168, 64'd184);
        send_byte(8'd97, 1'b0);
        send_byte(8'd98, 1'b0);
        load_settings(64'hFEDC_BA98_7654_3213, 64'h1F, 64'd0, 64'd168, 64'd184);
        for (int i = 0; i < 6; i++) send_byte(8'd65 + 8'(i), 1'b0);
        load_settings(64'hFEDC_BA98_7654_3213, 64'hFFFF_FFFF_FFFF_FFE3, 64'hFFFF_FFFE,
                      64'h1234_56A8, 64'hFF00_00B8);
        send_byte(8'd120, 1'b0);
        send_byte(8'd121, 1'b0);
        send_byte(8'd122, 1'b1);
    endtask

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 8'($urandom_range(32, 126));
        if (pick < 75) return 8'($urandom_range(192, 255));
        if (pick < 83) return pick[0] ? extra_a : extra_b;
        if (pick < 88) return pick[0] ? gcs_pkg::CHAR_NL : gcs_pkg::CHAR_TAB;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] random_letter();
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(32, 126));
            1: return 64'($urandom_range(192, 255));
            2: return 64'($urandom_range(0, 31));
            3: return {$urandom, $urandom};   // upper bits must be ignored
            default: return 64'($urandom_range(127, 191));
        endcase
    endfunction

    task automatic load_random_settings();
        logic [63:0] key;
        logic [63:0] len;
        case ($urandom_range(0, 3))
            0: key = '1;
            1: key = '0;
            default: key = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0: len = 64'd16;
            1: len = 64'd1;
            2: len = {$urandom, 27'd0, 5'($urandom_range(0, 31))};
            default: len = 64'($urandom_range(1, 16));
        endcase
        load_settings(key, len, {$urandom, 31'd0, 1'($urandom)}, random_letter(),
                      random_letter());
    endtask

    // Messages of random length under a new random setting every few dozen bytes.
    // Once per setting, sometimes, the sender holds off until the block has drained.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int sent;
        int seg_left;
        logic eom;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            load_random_settings();
            seg_left = $urandom_range(30, 70);
            while (seg_left > 0 && sent < n_items) begin
                eom = ($urandom_range(0, 9) == 0) || (seg_left == 1);
                send_byte(random_text_byte(), eom);
                sent++;
                seg_left--;
                if (seg_left == 20 && (sent < 60 || $urandom_range(0, 2) == 0))
                    drain_results();
            end
        end
    endtask

    initial begin
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'd0;
        s_axis_tlast    = 1'b0;
        m_axis_tready   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = gcs_pkg::CFG_KEY_DIGITS;
        cfg_data        = 64'd0;
        aresetn         = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        mismatches      = 0;
        bytes_sent      = 0;
        bytes_dropped   = 0;
        bytes_passed    = 0;
        results_seen    = 0;
        settings_loaded = 0;
        key_word        = 64'd0;
        key_len_reg     = 5'd1;
        decrypt_reg     = 1'b0;
        extra_a         = gcs_pkg::EXTRA_A_RST;
        extra_b         = gcs_pkg::EXTRA_B_RST;
        key_pos         = 4'd0;

        repeat (RESET_TICKS) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_shift_wrap();
        test_extra_letters();
        test_key_length_limits();
        test_random_traffic(35, 68, ITEMS_PER_PHASE);
        test_random_traffic(68, 35, ITEMS_PER_PHASE);
        test_random_traffic(0, 0, ITEMS_PER_PHASE);
        drain_results();

        $display("Sent %0d bytes (%0d dropped, %0d newline or tab) under %0d key settings.",
                 bytes_sent, bytes_dropped, bytes_passed, settings_loaded);
        $display("Compared %0d results, %0d of them wrong or unexpected.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding.", pending_cipher_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/gcs_pkg.sv
src/gronsfeld_cipher_stream_top.sv
verif/tb_gronsfeld_cipher_stream_top.sv
